FILE: hdl/nppq_pkg.sv
`default_nettype none

package nppq_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_ADDR_W    = $clog2(PALETTE_DEPTH);
   localparam int MAX_ROW_WIDTH = 2048;

   localparam int COLOR_W   = 8;
   localparam int ENTRY_W   = 3 * COLOR_W;
   localparam int SQ_W      = 2 * COLOR_W;
   localparam int DIST_W    = SQ_W + 2;
   localparam int COUNT_W   = 9;
   localparam int ROW_W     = 12;
   localparam int PIX_W     = 11;
   localparam int BITS_W    = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 12;

   localparam logic [COUNT_W-1:0] COLOR_COUNT_RESET = 9'd2;
   localparam logic [ROW_W-1:0]   ROW_WIDTH_RESET   = 12'd640;
   localparam logic [COUNT_W-1:0] PALETTE_DEPTH_C   = COUNT_W'(PALETTE_DEPTH);
   localparam logic [ROW_W-1:0]   MAX_ROW_WIDTH_C   = ROW_W'(MAX_ROW_WIDTH);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH   = 1'b1;

   // request kinds
   localparam logic REQ_PALETTE = 1'b0;
   localparam logic REQ_PIXEL   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   // bits per index: 1 for up to 2 colors, 4 for up to 16, else 8
   function automatic logic [BITS_W-1:0] depth_of(input logic [COUNT_W-1:0] count);
      logic [BITS_W-1:0] depth;
      if (count <= 9'd2) begin
         depth = 4'd1;
      end else if (count <= 9'd16) begin
         depth = 4'd4;
      end else begin
         depth = 4'd8;
      end
      return depth;
   endfunction

   function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                                 input logic [COLOR_W-1:0] b);
      logic [COLOR_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

endpackage

`default_nettype wire

FILE: hdl/nppq_if.sv
`default_nettype none

interface nppq_req_if;
   logic                               valid;
   logic                               ready;
   logic                               req_type;
   logic [nppq_pkg::PAL_ADDR_W-1:0]    entry_index;
   logic [nppq_pkg::COLOR_W-1:0]       color_red;
   logic [nppq_pkg::COLOR_W-1:0]       color_green;
   logic [nppq_pkg::COLOR_W-1:0]       color_blue;

   modport source (output valid, req_type, entry_index, color_red, color_green, color_blue,
                   input ready);
   modport sink   (input valid, req_type, entry_index, color_red, color_green, color_blue,
                   output ready);
endinterface

interface nppq_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] packed_byte;
   logic       row_last;

   modport source (output valid, packed_byte, row_last, input ready);
   modport sink   (input valid, packed_byte, row_last, output ready);
endinterface

`default_nettype wire

FILE: hdl/nppq_ram.sv
`default_nettype none

module nppq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/nearest_palette_quantize_pack_top.sv
// Nearest-color palette quantizer with packed row output.
// Requests arrive on req_if (valid/ready). A request with req_type 0 writes
// palette slot entry_index with its RGB color and gives no response. A
// request with req_type 1 is a pixel: the first color_count palette
// entries are scanned one per cycle from a dual-port palette RAM (one write
// port, one read port), and the entry with the least squared RGB distance
// (lowest index on a tie) is packed MSB first at 1, 4 or 8 bits per pixel.
// Responses on rsp_if carry packed bytes; at the end of each row_width
// pixels the partial byte is flushed, zero bytes pad the row to a multiple
// of 4 bytes and row_last marks the final byte. A pixel gives 0 to 4 bytes.
// For a pixel, n being color_count capped at 256, the path to its first byte
// is: n RAM reads, the square and compare stages, a check that the pipeline
// is empty, the packing step and the output register load (n = 0 skips the
// search). Further bytes follow one per cycle while rsp_if.ready is high. A
// new pixel is taken only in the idle state, once every byte of the last one
// has been loaded into the output register. A stalled receiver holds the
// output register and, once it is full, the byte sequencer and the input.
// Synchronous reset clears the packing state and sets color_count to 2 and
// row_width to 640. Palette contents are undefined until written.
`default_nettype none

module nearest_palette_quantize_pack_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   nppq_req_if.sink                                 req_if,
   nppq_rsp_if.source                               rsp_if,
   input  wire logic                                csr_wr_en,
   input  wire logic [nppq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [nppq_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int AW = nppq_pkg::PAL_ADDR_W;
   localparam int CW = nppq_pkg::COLOR_W;

   nppq_pkg::state_type state_ff, state_in;

   logic [nppq_pkg::COUNT_W-1:0] color_count_ff;
   logic [nppq_pkg::ROW_W-1:0]   row_width_ff;

   logic [CW-1:0] pix_r_ff, pix_g_ff, pix_b_ff;

   logic [nppq_pkg::COUNT_W-1:0] cnt_ff, cnt_in;
   logic                         s1_valid_ff, s1_valid_in;
   logic [AW-1:0]                s1_idx_ff;
   logic                         s2_valid_ff;
   logic [AW-1:0]                s2_idx_ff;
   logic [nppq_pkg::SQ_W-1:0]    sq_r_ff, sq_g_ff, sq_b_ff;
   logic [nppq_pkg::DIST_W-1:0]  best_dist_ff;
   logic [AW-1:0]                best_idx_ff, best_idx_in;
   logic                         best_none_ff, best_none_in;

   logic [nppq_pkg::PIX_W-1:0]   pixel_ff, pixel_in;
   logic [7:0]                   acc_ff, acc_in;
   logic [nppq_pkg::BITS_W-1:0]  bits_ff, bits_in;
   logic [1:0]                   mod4_ff, mod4_in;

   logic [7:0]                   emit_byte_ff, emit_byte_in;
   logic                         emit_row_end_ff, emit_row_end_in;
   logic [2:0]                   emit_left_ff, emit_left_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;

   logic                          req_fire;
   logic                          ram_wr_en;
   logic                          ram_rd_en;
   logic [nppq_pkg::ENTRY_W-1:0]  ram_rd_data;
   logic                          out_free;

   logic [nppq_pkg::COUNT_W-1:0]  n_eff;
   logic [nppq_pkg::BITS_W-1:0]   depth;
   logic [7:0]                    idx_mask;
   logic [7:0]                    idx_m;
   logic [7:0]                    acc_new;
   logic [nppq_pkg::BITS_W-1:0]   bits_new;
   logic                          full;
   logic [7:0]                    data_byte;
   logic [nppq_pkg::ROW_W-1:0]    width_eff;
   logic                          row_end;
   logic [nppq_pkg::DIST_W-1:0]   entry_dist;
   logic                          take;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         color_count_ff <= nppq_pkg::COLOR_COUNT_RESET;
         row_width_ff   <= nppq_pkg::ROW_WIDTH_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            nppq_pkg::CSR_COLOR_COUNT: color_count_ff <= csr_wr_data[nppq_pkg::COUNT_W-1:0];
            nppq_pkg::CSR_ROW_WIDTH:   row_width_ff   <= csr_wr_data[nppq_pkg::ROW_W-1:0];
            default: ;
         endcase
      end
   end

   assign n_eff = (color_count_ff > nppq_pkg::PALETTE_DEPTH_C) ?
                  nppq_pkg::PALETTE_DEPTH_C : color_count_ff;
   assign depth = nppq_pkg::depth_of(n_eff);

   always_comb begin
      if (row_width_ff == '0) begin
         width_eff = 12'd1;
      end else if (row_width_ff > nppq_pkg::MAX_ROW_WIDTH_C) begin
         width_eff = nppq_pkg::MAX_ROW_WIDTH_C;
      end else begin
         width_eff = row_width_ff;
      end
   end

   // ---------------- palette memory ----------------
   assign req_if.ready = (state_ff == nppq_pkg::ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign ram_wr_en    = req_fire && (req_if.req_type == nppq_pkg::REQ_PALETTE) &&
                         ({1'b0, req_if.entry_index} < nppq_pkg::PALETTE_DEPTH_C);
   assign ram_rd_en    = (state_ff == nppq_pkg::ST_SEARCH) && (cnt_ff < n_eff);

   nppq_ram #(
      .WIDTH(nppq_pkg::ENTRY_W),
      .DEPTH(nppq_pkg::PALETTE_DEPTH)
   ) u_palette (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(req_if.entry_index),
      .wr_data({req_if.color_red, req_if.color_green, req_if.color_blue}),
      .rd_en  (ram_rd_en),
      .rd_addr(cnt_ff[AW-1:0]),
      .rd_data(ram_rd_data)
   );

   // ---------------- search pipeline ----------------
   assign entry_dist = nppq_pkg::DIST_W'(sq_r_ff) + nppq_pkg::DIST_W'(sq_g_ff) +
                       nppq_pkg::DIST_W'(sq_b_ff);
   assign take = s2_valid_ff && (best_none_ff || (entry_dist < best_dist_ff));

   assign s1_valid_in = ram_rd_en;

   always_ff @(posedge clock) begin
      s1_idx_ff <= cnt_ff[AW-1:0];
      s2_idx_ff <= s1_idx_ff;
      sq_r_ff   <= nppq_pkg::sq_diff(pix_r_ff, ram_rd_data[3*CW-1:2*CW]);
      sq_g_ff   <= nppq_pkg::sq_diff(pix_g_ff, ram_rd_data[2*CW-1:CW]);
      sq_b_ff   <= nppq_pkg::sq_diff(pix_b_ff, ram_rd_data[CW-1:0]);
      if (take) begin
         best_dist_ff <= entry_dist;
      end
      if (req_fire) begin
         pix_r_ff <= req_if.color_red;
         pix_g_ff <= req_if.color_green;
         pix_b_ff <= req_if.color_blue;
      end
   end

   // ---------------- packing ----------------
   always_comb begin
      case (depth)
         4'd1:    idx_mask = 8'h01;
         4'd4:    idx_mask = 8'h0F;
         default: idx_mask = 8'hFF;
      endcase
   end

   assign idx_m    = 8'(best_idx_ff) & idx_mask;
   assign acc_new  = (acc_ff << depth) | idx_m;
   assign bits_new = bits_ff + depth;
   assign full     = (bits_new >= 4'd8);
   assign data_byte = full ? acc_new : (acc_new << (4'd8 - bits_new));
   assign row_end  = ({1'b0, pixel_ff} + 12'd1) >= width_eff;

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // ---------------- control ----------------
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      best_idx_in     = take ? s2_idx_ff : best_idx_ff;
      best_none_in    = best_none_ff && !take;
      pixel_in        = pixel_ff;
      acc_in          = acc_ff;
      bits_in         = bits_ff;
      mod4_in         = mod4_ff;
      emit_byte_in    = emit_byte_ff;
      emit_row_end_in = emit_row_end_ff;
      emit_left_in    = emit_left_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      rsp_byte_in     = rsp_byte_ff;
      rsp_last_in     = rsp_last_ff;

      case (state_ff)
         nppq_pkg::ST_IDLE: begin
            if (req_fire && (req_if.req_type == nppq_pkg::REQ_PIXEL)) begin
               cnt_in       = '0;
               best_idx_in  = '0;
               best_none_in = 1'b1;
               // no entry to search: index 0 stands
               state_in     = (n_eff == '0) ? nppq_pkg::ST_FINISH : nppq_pkg::ST_SEARCH;
            end
         end
         nppq_pkg::ST_SEARCH: begin
            if (ram_rd_en) begin
               cnt_in = cnt_ff + 9'd1;
            end else if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = nppq_pkg::ST_FINISH;
            end
         end
         nppq_pkg::ST_FINISH: begin
            emit_byte_in    = data_byte;
            emit_row_end_in = row_end;
            if (row_end) begin
               emit_left_in = {1'b0, 2'd3 - mod4_ff} + 3'd1;
               pixel_in     = '0;
               acc_in       = '0;
               bits_in      = '0;
               mod4_in      = '0;
            end else begin
               emit_left_in = full ? 3'd1 : 3'd0;
               pixel_in     = pixel_ff + 11'd1;
               if (full) begin
                  acc_in  = '0;
                  bits_in = '0;
                  mod4_in = mod4_ff + 2'd1;
               end else begin
                  acc_in  = acc_new;
                  bits_in = bits_new;
               end
            end
            state_in = (full || row_end) ? nppq_pkg::ST_EMIT : nppq_pkg::ST_IDLE;
         end
         nppq_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = emit_byte_ff;
               rsp_last_in  = emit_row_end_ff && (emit_left_ff == 3'd1);
               // padding bytes follow the data byte
               emit_byte_in = '0;
               emit_left_in = emit_left_ff - 3'd1;
               if (emit_left_ff == 3'd1) begin
                  state_in = nppq_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = nppq_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nppq_pkg::ST_IDLE;
         cnt_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         best_none_ff <= 1'b1;
         best_idx_ff  <= '0;
         pixel_ff     <= '0;
         acc_ff       <= '0;
         bits_ff      <= '0;
         mod4_ff      <= '0;
         emit_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         best_none_ff <= best_none_in;
         best_idx_ff  <= best_idx_in;
         pixel_ff     <= pixel_in;
         acc_ff       <= acc_in;
         bits_ff      <= bits_in;
         mod4_ff      <= mod4_in;
         emit_left_ff <= emit_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      emit_byte_ff    <= emit_byte_in;
      emit_row_end_ff <= emit_row_end_in;
      rsp_byte_ff     <= rsp_byte_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.packed_byte = rsp_byte_ff;
   assign rsp_if.row_last    = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register is not one-hot");

   a_no_write_in_search: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("palette written while a search reads it");

   a_pipe_in_search: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff || s2_valid_ff) |-> (state_ff == nppq_pkg::ST_SEARCH))
      else $error("search pipeline busy outside search");

   a_bits_partial: assert property (@(posedge clock) disable iff (reset)
      bits_ff < 4'd8)
      else $error("accumulator holds a full byte");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nppq_pkg::ST_EMIT) |-> ((emit_left_ff != 3'd0) && (emit_left_ff <= 3'd4)))
      else $error("byte sequencer count out of range");
`endif

endmodule

`default_nettype wire
